// ===== src/nlr_pkg.sv =====
// Shared types and constants for the net level resolver.
// No dependencies; every other file of the block but nlr_if refers to this package.
`default_nettype none

package nlr_pkg;

  // Level codes as stored and reported.
  localparam logic [1:0] LVL_LOW     = 2'd0;
  localparam logic [1:0] LVL_HIGH    = 2'd1;
  localparam logic [1:0] LVL_NC      = 2'd2;
  localparam logic [1:0] LVL_INVALID = 2'd3;

  // Verdict codes for the first decisive event of a pass.
  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_HIGH    = 2'd1;
  localparam logic [1:0] VERDICT_INVALID = 2'd2;

  // Pin drive codes.
  localparam logic [2:0] DRV_PASSIVE = 3'd0;
  localparam logic [2:0] DRV_WR_LOW  = 3'd1;
  localparam logic [2:0] DRV_WR_HIGH = 3'd2;
  localparam logic [2:0] DRV_RW_LOW  = 3'd3;
  localparam logic [2:0] DRV_RW_HIGH = 3'd4;
  localparam logic [2:0] DRV_INVALID = 3'd5;

  // Start-up delay and toggle counter limits.
  localparam logic [3:0] RESET_DELAY = 4'd10;
  localparam logic [5:0] TOGGLE_MAX  = 6'd63;

  // Configuration register reset values and addressing.
  localparam logic [5:0] OSC_LIMIT_RST = 6'd50;
  localparam logic [7:0] DROP_THR_RST  = 8'd127;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_OSC_LIMIT = 1'b0;
  localparam logic REG_DROP_THR  = 1'b1;

  // One pin request.
  typedef struct packed {
    logic [2:0] pin_drive;
    logic       last_pin;
    logic       net_dirty;
    logic [7:0] random_byte;
  } item_t;

  // One resolution result.
  typedef struct packed {
    logic [1:0] net_level;
    logic       notify_hosts;
    logic       update_dropped;
  } result_t;

  // Configuration register contents.
  typedef struct packed {
    logic [5:0] osc_limit;
    logic [7:0] drop_thr;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/nlr_if.sv =====
// Valid/ready channel interfaces for pin requests and resolution results.
// Depends on nothing; field widths follow the package types.
`default_nettype none

interface nlr_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] pin_drive;
  logic       last_pin;
  logic       net_dirty;
  logic [7:0] random_byte;

  modport source (output valid, pin_drive, last_pin, net_dirty, random_byte, input ready);
  modport sink   (input valid, pin_drive, last_pin, net_dirty, random_byte, output ready);
endinterface

interface nlr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] net_level;
  logic       notify_hosts;
  logic       update_dropped;

  modport source (output valid, net_level, notify_hosts, update_dropped, input ready);
  modport sink   (input valid, net_level, notify_hosts, update_dropped, output ready);
endinterface

`default_nettype wire

// ===== src/nlr_regs.sv =====
// APB-style configuration registers of the net level resolver.
// Depends on nlr_pkg for the register layout and reset values.
`default_nettype none

module nlr_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [nlr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [nlr_pkg::DATA_W-1:0] pwdata,
  output logic      [nlr_pkg::DATA_W-1:0] prdata,
  output logic                           pready,
  output nlr_pkg::cfg_t                  cfg_o
);

  logic [5:0] osc_limit_q;
  logic [7:0] drop_thr_q;
  logic       wr_en;

  // A write completes in the access phase; pready is always high.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osc_limit_q <= nlr_pkg::OSC_LIMIT_RST;
      drop_thr_q  <= nlr_pkg::DROP_THR_RST;
    end else if (wr_en) begin
      case (paddr[2])
        nlr_pkg::REG_OSC_LIMIT: osc_limit_q <= pwdata[5:0];
        nlr_pkg::REG_DROP_THR:  drop_thr_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register, zero extended.
  always_comb begin
    case (paddr[2])
      nlr_pkg::REG_OSC_LIMIT: prdata = {{(nlr_pkg::DATA_W-6){1'b0}}, osc_limit_q};
      nlr_pkg::REG_DROP_THR:  prdata = {{(nlr_pkg::DATA_W-8){1'b0}}, drop_thr_q};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o.osc_limit = osc_limit_q;
  assign cfg_o.drop_thr  = drop_thr_q;

endmodule

`default_nettype wire

// ===== src/nlr_core.sv =====
// Per-pin state update and final-pin resolution of the net level.
// Depends on nlr_pkg for codes and the request, result and config types.
`default_nettype none

module nlr_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire nlr_pkg::item_t   item_i,
  input  wire nlr_pkg::cfg_t    cfg_i,
  output nlr_pkg::result_t      result_o
);

  logic [1:0] level_q, level_d;
  logic [5:0] toggle_q, toggle_d;
  logic [3:0] delay_q, delay_d;
  logic [1:0] verdict_q, verdict_d;
  logic       wr_seen_q, wr_seen_d;
  logic       wr_lvl_q, wr_lvl_d;
  logic       fb_seen_q, fb_seen_d;
  logic       fb_lvl_q, fb_lvl_d;
  logic       forced_q, forced_d;

  // Pass state after taking this pin, before any end-of-pass clear.
  logic [1:0] tk_verdict;
  logic       tk_wr_seen, tk_wr_lvl, tk_fb_seen, tk_fb_lvl, tk_forced;
  logic [1:0] next_lvl;
  logic [5:0] toggle_inc;
  logic       dirty, notify, dropped, is_toggle;

  // Take one pin; only the first decisive event of a pass counts.
  always_comb begin
    tk_verdict = verdict_q;
    tk_wr_seen = wr_seen_q;
    tk_wr_lvl  = wr_lvl_q;
    tk_fb_seen = fb_seen_q;
    tk_fb_lvl  = fb_lvl_q;
    tk_forced  = forced_q;
    delay_d    = delay_q;
    if (verdict_q == nlr_pkg::VERDICT_NONE) begin
      case (item_i.pin_drive)
        nlr_pkg::DRV_INVALID: begin
          if (delay_q != 4'd0) begin
            delay_d    = delay_q - 4'd1;
            tk_forced  = 1'b1;
            tk_verdict = nlr_pkg::VERDICT_HIGH;
          end else begin
            tk_verdict = nlr_pkg::VERDICT_INVALID;
          end
        end
        nlr_pkg::DRV_RW_LOW, nlr_pkg::DRV_RW_HIGH: begin
          tk_fb_seen = 1'b1;
          tk_fb_lvl  = (item_i.pin_drive == nlr_pkg::DRV_RW_HIGH);
        end
        nlr_pkg::DRV_WR_LOW, nlr_pkg::DRV_WR_HIGH: begin
          if (wr_seen_q) begin
            tk_verdict = nlr_pkg::VERDICT_INVALID;
          end else begin
            tk_wr_seen = 1'b1;
            tk_wr_lvl  = (item_i.pin_drive == nlr_pkg::DRV_WR_HIGH);
          end
        end
        default: ;
      endcase
    end
  end

  // Resolve the level the net would take after this pass.
  always_comb begin
    if (tk_verdict == nlr_pkg::VERDICT_HIGH) begin
      next_lvl = nlr_pkg::LVL_HIGH;
    end else if (tk_verdict == nlr_pkg::VERDICT_INVALID) begin
      next_lvl = nlr_pkg::LVL_INVALID;
    end else if (tk_wr_seen) begin
      next_lvl = tk_wr_lvl ? nlr_pkg::LVL_HIGH : nlr_pkg::LVL_LOW;
    end else if (tk_fb_seen) begin
      next_lvl = tk_fb_lvl ? nlr_pkg::LVL_HIGH : nlr_pkg::LVL_LOW;
    end else begin
      next_lvl = nlr_pkg::LVL_NC;
    end
  end

  // Notification, toggle counting and random suppression on the last pin.
  assign dirty      = item_i.net_dirty | tk_forced;
  assign is_toggle  = ((next_lvl == nlr_pkg::LVL_HIGH) && (level_q == nlr_pkg::LVL_LOW)) ||
                      ((next_lvl == nlr_pkg::LVL_LOW) && (level_q == nlr_pkg::LVL_HIGH));
  assign toggle_inc = (toggle_q != nlr_pkg::TOGGLE_MAX) ? toggle_q + 6'd1 : toggle_q;

  always_comb begin
    notify   = 1'b0;
    dropped  = 1'b0;
    toggle_d = toggle_q;
    level_d  = level_q;
    if (item_i.last_pin && ((next_lvl != level_q) || dirty)) begin
      notify = 1'b1;
      if (is_toggle) begin
        if (toggle_inc > cfg_i.osc_limit) begin
          toggle_d = 6'd0;
          dropped  = (item_i.random_byte > cfg_i.drop_thr);
        end else begin
          toggle_d = toggle_inc;
        end
      end else begin
        toggle_d = 6'd0;
      end
      if (!dropped) begin
        level_d = next_lvl;
      end
    end
  end

  // The last pin clears the per-pass state.
  always_comb begin
    if (item_i.last_pin) begin
      verdict_d = nlr_pkg::VERDICT_NONE;
      wr_seen_d = 1'b0;
      wr_lvl_d  = 1'b0;
      fb_seen_d = 1'b0;
      fb_lvl_d  = 1'b0;
      forced_d  = 1'b0;
    end else begin
      verdict_d = tk_verdict;
      wr_seen_d = tk_wr_seen;
      wr_lvl_d  = tk_wr_lvl;
      fb_seen_d = tk_fb_seen;
      fb_lvl_d  = tk_fb_lvl;
      forced_d  = tk_forced;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= nlr_pkg::LVL_HIGH;
      toggle_q  <= 6'd0;
      delay_q   <= nlr_pkg::RESET_DELAY;
      verdict_q <= nlr_pkg::VERDICT_NONE;
      wr_seen_q <= 1'b0;
      wr_lvl_q  <= 1'b0;
      fb_seen_q <= 1'b0;
      fb_lvl_q  <= 1'b0;
      forced_q  <= 1'b0;
    end else if (step_i) begin
      level_q   <= level_d;
      toggle_q  <= toggle_d;
      delay_q   <= delay_d;
      verdict_q <= verdict_d;
      wr_seen_q <= wr_seen_d;
      wr_lvl_q  <= wr_lvl_d;
      fb_seen_q <= fb_seen_d;
      fb_lvl_q  <= fb_lvl_d;
      forced_q  <= forced_d;
    end
  end

  assign result_o.net_level      = level_d;
  assign result_o.notify_hosts   = notify;
  assign result_o.update_dropped = dropped;

endmodule

`default_nettype wire

// ===== src/net_level_resolver.sv =====
// Top level of the net level resolver: input register, core, result register.
// Depends on nlr_pkg, nlr_if, nlr_regs and nlr_core.
//
//   channel   dir   kind           carries
//   req_i     in    valid/ready    pin_drive, last_pin, net_dirty, random_byte
//   res_o     out   valid/ready    net_level, notify_hosts, update_dropped
//   apb       in    APB, 3b addr   oscillation_limit @0x0, drop_threshold @0x4
//
// One request is accepted per cycle unless a final pin in the input register
// waits for the result register. A request is registered, resolved by the
// core, and a final pin loads the result register. Only a final pin needs
// the result register free; other pins always move on. Reset is asynchronous
// and active low, and returns the level to high and the start-up delay to ten.
`default_nettype none

module net_level_resolver (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  nlr_in_if.sink                          req_i,
  nlr_out_if.source                       res_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [nlr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [nlr_pkg::DATA_W-1:0] pwdata,
  output logic      [nlr_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  nlr_pkg::cfg_t    cfg;
  nlr_pkg::item_t   in_item, s1_item_q;
  nlr_pkg::result_t core_res, out_res_q;
  logic             s1_valid_q, out_valid_q;
  logic             out_free, s1_fire, in_fire;

  // Configuration registers.
  nlr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the registered request moves on unless it is a final pin
  // and the result register is still occupied.
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_fire     = s1_valid_q && (!s1_item_q.last_pin || out_free);
  assign req_i.ready = !s1_valid_q || s1_fire;
  assign in_fire     = req_i.valid && req_i.ready;

  assign in_item.pin_drive   = req_i.pin_drive;
  assign in_item.last_pin    = req_i.last_pin;
  assign in_item.net_dirty   = req_i.net_dirty;
  assign in_item.random_byte = req_i.random_byte;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item;
    end
  end

  // Net state and resolution.
  nlr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_fire),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (core_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_item_q.last_pin) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item_q.last_pin) begin
      out_res_q <= core_res;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.net_level      = out_res_q.net_level;
  assign res_o.notify_hosts   = out_res_q.notify_hosts;
  assign res_o.update_dropped = out_res_q.update_dropped;

endmodule

`default_nettype wire

// ===== src/nlr_checker.sv =====
// Port-level assertions for the net level resolver, bound to its top level.
// Depends on nlr_pkg for level codes.
`default_nettype none

module nlr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       res_valid_i,
  input wire logic       res_ready_i,
  input wire logic [1:0] res_level_i,
  input wire logic       res_notify_i,
  input wire logic       res_dropped_i,
  input wire logic       pready_i
);

  logic       res_fire;
  logic [1:0] last_lvl_q;

  assign res_fire = res_valid_i && res_ready_i;

  // Level last delivered; the net starts high after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_lvl_q <= nlr_pkg::LVL_HIGH;
    end else if (res_fire) begin
      last_lvl_q <= res_level_i;
    end
  end

  // A stalled result holds its value.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_level_i) &&
    $stable(res_notify_i) && $stable(res_dropped_i))
    else $error("result changed while stalled");

  // A suppressed update is always announced to the hosts.
  a_drop_notify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_dropped_i |-> res_notify_i)
    else $error("dropped update without notification");

  // Without notification the level cannot change.
  a_quiet_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && !res_notify_i |-> res_level_i == last_lvl_q)
    else $error("level changed without notification");

  // A suppressed update keeps the previous level.
  a_drop_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire && res_dropped_i |-> res_level_i == last_lvl_q)
    else $error("dropped update changed the level");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

endmodule

bind net_level_resolver nlr_checker u_nlr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_level_i   (res_o.net_level),
  .res_notify_i  (res_o.notify_hosts),
  .res_dropped_i (res_o.update_dropped),
  .pready_i      (pready)
);

`default_nettype wire
